// ----- sv/assert_macros.svh -----
// Assertion macros used by the heap sequencer of the heap priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge of clk while arst_n is high.
`define ASSERT_CLK(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Condition that must never be true while out of reset.
`define ASSERT_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, prop)
`define ASSERT_NEVER(name, cond)

`endif

`endif

// ----- sv/hpq_pkg.sv -----
// Types and constants shared by the heap priority queue modules.
`default_nettype none

package hpq_pkg;

	localparam int CAPACITY  = 256;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int KEY_W     = 32;
	localparam int OUT_CNT_W = 9;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef enum logic {
		MODE_INSERT  = 1'b0,
		MODE_EXTRACT = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		key_t                   key_out;
		status_t                status;
		logic [OUT_CNT_W-1:0]   count;
	} res_t;

endpackage

`default_nettype wire

// ----- sv/max_heap_priority_queue_top.sv -----
// Top level of the binary max-heap priority queue with its stream ports.
`default_nettype none

// Binary max-heap priority queue over signed 32-bit keys, holding up to 256 keys in a
// single RAM. Each input item either inserts a key (tuser 0) or extracts the maximum
// (tuser 1) and yields exactly one result item with the key, a status and the new count.
// An item takes its cycles in one sequencer that does one RAM read or write per step.
// An insert climbs the key level by level until it reaches the root or a parent stops
// it. An extract reads the root and the last key, then sinks that key level by level
// while a larger child is found. A rejected request goes straight to its result.
// The input is not ready while an item is in work. A result register decouples the
// output, so a new item is taken while the last result waits.
module max_heap_priority_queue_top
	import hpq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] key_in
	input  wire logic [0:0]  s_axis_tuser,  // [0] mode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // [31:0] key_out, [40:32] count, rest zero
	output logic [1:0]       m_axis_tuser   // [1:0] status
);

	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	key_t              ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	key_t              ram_rdata;
	logic              out_valid_q;
	res_t              out_res_q;

	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (mode_t'(s_axis_tuser[0])),
		.in_key    (key_t'(s_axis_tdata)),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	hpq_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The result register takes a new item when empty or when its item leaves.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_res_q.count, out_res_q.key_out};
	assign m_axis_tuser  = out_res_q.status;

endmodule

`default_nettype wire

// ----- sv/hpq_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module hpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- sv/hpq_ctrl.sv -----
// Heap sequencer: sift-up and sift-down over the key RAM with one shared comparator.
`default_nettype none

module hpq_ctrl
	import hpq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire mode_t             in_mode,
	input  wire key_t              in_key,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output res_t                   res,
	output logic                   ram_we,
	output logic [ADDR_W-1:0]      ram_waddr,
	output key_t                   ram_wdata,
	output logic [ADDR_W-1:0]      ram_raddr,
	input  wire key_t              ram_rdata
);

	`include "assert_macros.svh"

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_UP_CHK  = 10'b00_0000_0010,
		S_UP_CMP  = 10'b00_0000_0100,
		S_EX_ROOT = 10'b00_0000_1000,
		S_EX_LAST = 10'b00_0001_0000,
		S_DN_CHK  = 10'b00_0010_0000,
		S_DN_L    = 10'b00_0100_0000,
		S_DN_R    = 10'b00_1000_0000,
		S_DN_CMP  = 10'b01_0000_0000,
		S_DONE    = 10'b10_0000_0000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] chsel_q;
	key_t             key_q;
	key_t             key_out_q;
	key_t             child_q;
	status_t          status_q;

	logic [CNT_W-1:0] pos_m1;
	logic [CNT_W-1:0] par;
	logic [CNT_W-1:0] par_m1;
	logic [CNT_W:0]   ch;
	logic [CNT_W:0]   ch_m1;
	logic [CNT_W:0]   count_ext;
	key_t             cmp_a;
	key_t             cmp_b;
	logic             cmp_gt;

	assign pos_m1    = pos_q - CNT_W'(1);
	assign par       = pos_q >> 1;
	assign par_m1    = par - CNT_W'(1);
	assign ch        = {pos_q, 1'b0};
	assign ch_m1     = ch - (CNT_W + 1)'(1);
	assign count_ext = {1'b0, count_q};

	// The one comparator of the block; its operands follow the sequencer state.
	always_comb begin
		case (state_q)
			S_UP_CMP: begin
				cmp_a = key_q;
				cmp_b = ram_rdata;
			end
			S_DN_R: begin
				cmp_a = ram_rdata;
				cmp_b = child_q;
			end
			default: begin
				cmp_a = child_q;
				cmp_b = key_q;
			end
		endcase
		cmp_gt = cmp_a > cmp_b;
	end

	// The moving key is carried in key_q and written only once its slot is final.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_m1[ADDR_W-1:0];
		ram_wdata = key_q;
		ram_raddr = '0;
		case (state_q)
			S_UP_CHK: begin
				if (pos_q == CNT_W'(1)) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = par_m1[ADDR_W-1:0];
				end
			end
			S_UP_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = cmp_gt ? ram_rdata : key_q;
			end
			S_EX_ROOT: begin
				ram_raddr = count_q[ADDR_W-1:0];
			end
			S_DN_CHK: begin
				if (ch > count_ext) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = ch_m1[ADDR_W-1:0];
				end
			end
			S_DN_L: begin
				ram_raddr = ch[ADDR_W-1:0];
			end
			S_DN_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = cmp_gt ? child_q : key_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			pos_q     <= '0;
			chsel_q   <= '0;
			key_q     <= '0;
			key_out_q <= '0;
			child_q   <= '0;
			status_q  <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q     <= in_key;
						key_out_q <= '0;
						status_q  <= ST_OK;
						if (in_mode == MODE_INSERT) begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								count_q <= count_q + CNT_W'(1);
								pos_q   <= count_q + CNT_W'(1);
								state_q <= S_UP_CHK;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								count_q <= count_q - CNT_W'(1);
								state_q <= S_EX_ROOT;
							end
						end
					end
				end
				S_UP_CHK: begin
					state_q <= (pos_q == CNT_W'(1)) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_gt) begin
						pos_q   <= par;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_EX_ROOT: begin
					key_out_q <= ram_rdata;
					pos_q     <= CNT_W'(1);
					state_q   <= S_EX_LAST;
				end
				S_EX_LAST: begin
					key_q   <= ram_rdata;
					state_q <= S_DN_CHK;
				end
				S_DN_CHK: begin
					state_q <= (ch > count_ext) ? S_DONE : S_DN_L;
				end
				S_DN_L: begin
					child_q <= ram_rdata;
					chsel_q <= ch[CNT_W-1:0];
					state_q <= (ch < count_ext) ? S_DN_R : S_DN_CMP;
				end
				S_DN_R: begin
					// The right child wins only when strictly larger.
					if (cmp_gt) begin
						child_q <= ram_rdata;
						chsel_q <= chsel_q + CNT_W'(1);
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (cmp_gt) begin
						pos_q   <= chsel_q;
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign res_valid   = (state_q == S_DONE);
	assign res.key_out = key_out_q;
	assign res.status  = status_q;
	assign res.count   = OUT_CNT_W'(count_q);

	`ASSERT_NEVER(a_count_in_range, count_q > CNT_W'(CAPACITY))
	`ASSERT_CLK(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
	`ASSERT_NEVER(a_no_write_when_idle, ram_we && (in_ready || res_valid))
	`ASSERT_CLK(a_full_means_at_capacity,
		res_valid && res.status == ST_FULL |-> count_q == CNT_W'(CAPACITY))

endmodule

`default_nettype wire

// ----- dv/max_heap_priority_queue_top_test.sv -----
// Self-checking testbench for the max-heap priority queue with stream ports.
`default_nettype none

module max_heap_priority_queue_top_test
	import hpq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD    = 400;
	localparam int MAX_PRINTS   = 50;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] key_in
	logic [0:0]  s_axis_tuser;   // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // [31:0] key_out, [40:32] count, rest zero
	logic [1:0]  m_axis_tuser;   // [1:0] status

	// Predicted contents of the queue and the results still owed by the block.
	key_t heap_keys [CAPACITY];
	int   heap_size;
	res_t res_expected [$];

	bit flow_idle;
	int rx_hold_left;
	int error_count;
	int items_sent;
	int results_seen;
	int full_seen;
	int empty_seen;
	int idle_cycles;

	max_heap_priority_queue_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Applies one request to the predicted heap and returns the result it should produce.
	function automatic res_t heap_apply(mode_t m, key_t k);
		res_t r;
		int   pos;
		int   par;
		int   ch;
		key_t t;
		bit   done;
		r.key_out = '0;
		r.status  = ST_OK;
		if (m == MODE_INSERT) begin
			if (heap_size >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				heap_size++;
				pos = heap_size;
				heap_keys[pos - 1] = k;
				done = 1'b0;
				while (pos > 1 && !done) begin
					par = pos / 2;
					if (heap_keys[pos - 1] > heap_keys[par - 1]) begin
						t = heap_keys[par - 1];
						heap_keys[par - 1] = heap_keys[pos - 1];
						heap_keys[pos - 1] = t;
						pos = par;
					end else begin
						done = 1'b1;
					end
				end
			end
		end else begin
			if (heap_size == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.key_out = heap_keys[0];
				heap_keys[0] = heap_keys[heap_size - 1];
				heap_size--;
				pos = 1;
				done = 1'b0;
				while (2 * pos <= heap_size && !done) begin
					ch = 2 * pos;
					// The right child wins only when strictly larger than the left one.
					if (ch < heap_size && heap_keys[ch] > heap_keys[ch - 1])
						ch++;
					if (heap_keys[ch - 1] > heap_keys[pos - 1]) begin
						t = heap_keys[ch - 1];
						heap_keys[ch - 1] = heap_keys[pos - 1];
						heap_keys[pos - 1] = t;
						pos = ch;
					end else begin
						done = 1'b1;
					end
				end
			end
		end
		r.count = heap_size[OUT_CNT_W-1:0];
		return r;
	endfunction

	// Mostly full-range keys, with a share of extremes and a narrow band that forces ties.
	function automatic key_t pick_key();
		key_t k;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: k = 32'sh7FFF_FFFF;
					1: k = 32'sh8000_0000;
					2: k = '0;
					default: k = '1;
				endcase
			end
			1, 2, 3: k = key_t'($urandom_range(0, 15) - 8);
			default: k = key_t'($urandom);
		endcase
		return k;
	endfunction

	task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
		if (error_count < MAX_PRINTS)
			$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Offers one item, holding tvalid high from the previous item unless a gap is inserted.
	task automatic send_item(mode_t m, key_t k);
		int gap;
		if (flow_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			s_axis_tuser  <= 1'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= k;
		s_axis_tuser  <= m;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		res_expected.push_back(heap_apply(m, k));
		items_sent++;
	endtask

	// Receiver: random stall bursts, plus a long hold when a test requests one.
	initial begin : rx_flow
		int stall;
		stall = 0;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold_left--;
			end else if (flow_idle && stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else if (flow_idle && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				stall = $urandom_range(1, 15) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tuser == ST_FULL)
				full_seen++;
			if (m_axis_tuser == ST_EMPTY)
				empty_seen++;
			if (res_expected.size() == 0) begin
				report_mismatch("unexpected result", {m_axis_tuser, m_axis_tdata[45:0]}, '0);
			end else begin
				want = res_expected.pop_front();
				if (m_axis_tdata[31:0] !== want.key_out)
					report_mismatch("key_out", 48'(m_axis_tdata[31:0]),
						48'(unsigned'(want.key_out)));
				if (m_axis_tuser !== want.status)
					report_mismatch("status", 48'(m_axis_tuser), 48'(want.status));
				if (m_axis_tdata[40:32] !== want.count)
					report_mismatch("count", 48'(m_axis_tdata[40:32]), 48'(want.count));
				if (m_axis_tdata[47:41] !== '0)
					report_mismatch("tdata padding", 48'(m_axis_tdata[47:41]), '0);
			end
		end
	end

	// Ends the run when neither side has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_empty_extract();
		send_item(MODE_EXTRACT, '0);
		send_item(MODE_EXTRACT, '1);
	endtask

	// Extreme keys and ties, then drained past empty.
	task automatic test_extreme_keys();
		send_item(MODE_INSERT, '0);
		send_item(MODE_INSERT, 32'sh7FFF_FFFF);
		send_item(MODE_INSERT, 32'sh8000_0000);
		send_item(MODE_INSERT, '1);
		send_item(MODE_INSERT, 32'sd1);
		send_item(MODE_INSERT, 32'sd5);
		send_item(MODE_INSERT, 32'sd5);
		send_item(MODE_INSERT, 32'sd5);
		send_item(MODE_INSERT, 32'sh8000_0000);
		repeat (10) send_item(MODE_EXTRACT, key_t'($urandom));
	endtask

	// Fills to capacity, tries two inserts into the full heap, then drains past empty.
	task automatic test_fill_and_drain();
		repeat (CAPACITY) send_item(MODE_INSERT, pick_key());
		send_item(MODE_INSERT, 32'sh7FFF_FFFF);
		send_item(MODE_INSERT, pick_key());
		repeat (CAPACITY + 1) send_item(MODE_EXTRACT, key_t'($urandom));
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		@(posedge clk);
		rx_hold_left = LONG_HOLD;
		repeat (6) send_item(MODE_INSERT, pick_key());
		repeat (4) send_item(MODE_EXTRACT, key_t'($urandom));
	endtask

	// Insert-heavy, balanced, then extract-heavy phases so the level rises and falls.
	task automatic test_random_mix(int n_items);
		int ins_pct;
		for (int i = 0; i < n_items; i++) begin
			ins_pct = (i < n_items / 3) ? 70 : (i < 2 * n_items / 3) ? 50 : 25;
			if ($urandom_range(1, 100) <= ins_pct)
				send_item(MODE_INSERT, pick_key());
			else
				send_item(MODE_EXTRACT, key_t'($urandom));
		end
	endtask

	task automatic test_no_idle();
		flow_idle = 1'b0;
		test_random_mix(80);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		flow_idle     = 1'b1;
		rx_hold_left  = 0;
		heap_size     = 0;
		error_count   = 0;
		items_sent    = 0;
		results_seen  = 0;
		full_seen     = 0;
		empty_seen    = 0;
		idle_cycles   = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_extract();
		test_extreme_keys();
		test_fill_and_drain();
		test_backpressure();
		test_random_mix(450);
		test_no_idle();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (res_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (res_expected.size() != 0)
			report_mismatch("results never delivered", 48'(res_expected.size()), '0);

		$display("Sent %0d requests and checked %0d results, %0d of them full-heap inserts",
			items_sent, results_seen, full_seen);
		$display("and %0d empty extracts, under random idling and a long receiver hold.",
			empty_seen);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
